// ----- hw/rtl/set_assoc_cache_lru_lookup_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative cache lookup block
// Shared shorthand for concurrent checks on the rising clock edge.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_LRU_LOOKUP_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_LOOKUP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SACL_ASSERT_IMP(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SACL_ASSERT_NXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/sacl_pkg.sv -----
// ----------------------------------------------------------------------------
// sacl_pkg
// Types and constants shared by the set-associative cache lookup block.
// ----------------------------------------------------------------------------
package sacl_pkg;

  localparam int MAX_SETS_LOG2 = 10;
  localparam int MAX_WAYS      = 8;
  localparam int NUM_SETS      = 1 << MAX_SETS_LOG2;
  localparam int SET_W         = MAX_SETS_LOG2;
  localparam int WAY_W         = $clog2(MAX_WAYS);
  localparam int FILL_W        = $clog2(MAX_WAYS + 1);
  localparam int TAG_W         = 32;
  localparam int ADDR_W        = 32;
  localparam int CNT_W         = 32;
  localparam int CFG_DATA_W    = 5;
  localparam int CFG_IDX_W     = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_LOG2   = 2'd2;

  // One memory row holds everything about one set. The valid ways of a set
  // are always ways 0 .. fill-1, so the fill count doubles as the valid bits.
  typedef struct packed {
    logic [FILL_W-1:0]                fill;
    logic [MAX_WAYS-1:0][WAY_W-1:0]   order;
    logic [MAX_WAYS-1:0][TAG_W-1:0]   tags;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic             is_hit;
    logic [WAY_W-1:0] way;
  } lookup_res_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_t;

endpackage

// ----- hw/rtl/sacl_ram.sv -----
// ----------------------------------------------------------------------------
// sacl_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/sacl_update.sv -----
// ----------------------------------------------------------------------------
// sacl_update
// Tag compare, victim choice and recency update for one set row.
// ----------------------------------------------------------------------------
module sacl_update import sacl_pkg::*; (
  input  row_t              rd_row,
  input  logic [TAG_W-1:0]  tag,
  input  logic [FILL_W-1:0] ways,
  output row_t              wr_row,
  output lookup_res_t       res
);

  logic [FILL_W-1:0] n;
  logic              hit;
  logic [WAY_W-1:0]  hit_way;
  logic              found;
  logic [WAY_W-1:0]  hit_pos;
  logic [WAY_W-1:0]  way;
  logic [WAY_W-1:0]  pos;
  logic [WAY_W-1:0]  last_pos;
  logic [WAY_W-1:0]  lru_way;
  logic              promote;

  assign n        = (rd_row.fill > ways) ? ways : rd_row.fill;
  assign last_pos = WAY_W'(n - FILL_W'(1));
  assign lru_way  = rd_row.order[last_pos];

  // Lowest matching valid way wins.
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if ((FILL_W'(w) < n) && (rd_row.tags[w] == tag)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  // Position of the hit way in the recency list.
  always_comb begin
    found   = 1'b0;
    hit_pos = '0;
    for (int p = MAX_WAYS - 1; p >= 0; p--) begin
      if ((FILL_W'(p) < n) && (rd_row.order[p] == hit_way)) begin
        found   = 1'b1;
        hit_pos = WAY_W'(p);
      end
    end
  end

  always_comb begin
    wr_row  = rd_row;
    way     = hit_way;
    pos     = hit_pos;
    promote = found;
    if (!hit) begin
      promote = 1'b1;
      if (n < ways) begin
        way         = WAY_W'(n);
        pos         = WAY_W'(n);
        wr_row.fill = n + FILL_W'(1);
      end else begin
        way = ({1'b0, lru_way} >= ways) ? '0 : lru_way;
        pos = last_pos;
      end
      wr_row.tags[way] = tag;
    end
    if (promote) begin
      for (int i = 1; i < MAX_WAYS; i++) begin
        if (WAY_W'(i) <= pos) begin
          wr_row.order[i] = rd_row.order[i-1];
        end
      end
      wr_row.order[0] = way;
    end
    res.is_hit = hit;
    res.way    = way;
  end

endmodule

// ----- hw/rtl/set_assoc_cache_lru_lookup.sv -----
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup: the result register is loaded when a lookup completes.
// A new access is taken only after the previous one is written back, owing to the
//   read-modify-write of the set row in the single state memory (read, then write back).
// Reset and every register write outside a running pass start a clearing pass of all
//   1024 rows of the set memory; no access is taken until it ends.
// ----------------------------------------------------------------------------
`include "set_assoc_cache_lru_lookup_defines.svh"

// All per-set state (tags, recency list, fill count) lives in one row of a
// synchronous RAM, one row per set. An access computes its set and tag from
// the address when it is transferred in and issues the row read in the same
// cycle. In the following cycle the row comes out of the RAM, the update
// logic decides hit or miss and produces the new row. When the result can
// enter the output register, the row is written back. The input side only
// takes a new access after the write-back, so a following access to the same
// set always reads the updated row and no forwarding path is needed.
//
// The result register decouples the two sides: a finished result may wait
// for the consumer while the next access is already being read. A lookup
// whose result register is still occupied simply holds in the lookup state;
// the RAM read data stays put because no new read is issued.
//
// The three running totals are the result's counter fields themselves; they
// only change when a new result is loaded, so they are stable while a result
// waits to be taken.
module set_assoc_cache_lru_lookup import sacl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Access input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ADDR_W-1:0]     address,
  // Result output
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  is_hit,
  output logic [SET_W-1:0]      set_number,
  output logic [WAY_W-1:0]      way_number,
  output logic [CNT_W-1:0]      accesses_seen,
  output logic [CNT_W-1:0]      hits_seen,
  output logic [CNT_W-1:0]      misses_seen
);

  state_t state;
  state_t state_next;

  logic [SET_W-1:0] clear_idx;
  logic [4:0]       offset_bits;
  logic [3:0]       index_bits;
  logic [1:0]       ways_log2;
  logic [SET_W-1:0] cur_set;
  logic [TAG_W-1:0] cur_tag;

  // Address split for the incoming access. The index width is capped at the
  // number of sets that exist; a tag shift of 32 or more gives a zero tag.
  logic [3:0]        ib;
  logic [SET_W:0]    set_mask;
  logic [ADDR_W-1:0] shifted;
  logic [5:0]        tag_shift;
  logic [SET_W-1:0]  in_set;
  logic [TAG_W-1:0]  in_tag;
  logic [FILL_W-1:0] ways;

  logic        in_xfer;
  logic        done;
  logic        clearing;
  logic        ram_we;
  logic [SET_W-1:0] ram_waddr;
  row_t        ram_wdata;
  row_t        rd_row;
  row_t        wr_row;
  lookup_res_t res;

  assign ib        = (index_bits > 4'(MAX_SETS_LOG2)) ? 4'(MAX_SETS_LOG2) : index_bits;
  assign set_mask  = ((SET_W+1)'(1) << ib) - (SET_W+1)'(1);
  assign shifted   = address >> offset_bits;
  assign in_set    = shifted[SET_W-1:0] & set_mask[SET_W-1:0];
  assign tag_shift = {1'b0, offset_bits} + {2'b00, ib};
  assign in_tag    = TAG_W'(address >> tag_shift);
  assign ways      = FILL_W'(1) << ways_log2;

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign clearing = (state == ST_CLEAR);
  // A lookup completes once the result register is free or being emptied.
  assign done     = (state == ST_LOOK) && (!out_valid || out_ready);

  // The clearing pass only needs the fill count at zero; the tag and recency
  // fields of a cleared row are never read before they are written.
  assign ram_we    = clearing || done;
  assign ram_waddr = clearing ? clear_idx : cur_set;
  assign ram_wdata = clearing ? row_t'('0) : wr_row;

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_xfer),
    .raddr (in_set),
    .rdata (rd_row)
  );

  sacl_update u_update (
    .rd_row (rd_row),
    .tag    (cur_tag),
    .ways   (ways),
    .wr_row (wr_row),
    .res    (res)
  );

  // Next-state logic. A register write starts a clearing pass, or lets a running
  // one go on, so the cache starts empty under the new geometry.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clear_idx == SET_W'(NUM_SETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
    if (cfg_write_en && (cfg_index == CFG_OFFSET_BITS || cfg_index == CFG_INDEX_BITS ||
                         cfg_index == CFG_WAYS_LOG2)) begin
      state_next = ST_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Clearing pass row counter; reset to the first row whenever a pass starts.
  always_ff @(posedge clk) begin
    if (rst || state_next != ST_CLEAR || state != ST_CLEAR) begin
      clear_idx <= '0;
    end else begin
      clear_idx <= clear_idx + SET_W'(1);
    end
  end

  // Configuration registers. Indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= 5'd4;
      index_bits  <= 4'd6;
      ways_log2   <= 2'd2;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_OFFSET_BITS: offset_bits <= cfg_data[4:0];
        CFG_INDEX_BITS:  index_bits  <= cfg_data[3:0];
        CFG_WAYS_LOG2:   ways_log2   <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  // Access held for the lookup state.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cur_set <= in_set;
      cur_tag <= in_tag;
    end
  end

  // Result register and saturating totals.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      accesses_seen <= '0;
      hits_seen     <= '0;
      misses_seen   <= '0;
    end else if (done) begin
      out_valid     <= 1'b1;
      accesses_seen <= (accesses_seen == '1) ? accesses_seen : accesses_seen + CNT_W'(1);
      if (res.is_hit) begin
        hits_seen <= (hits_seen == '1) ? hits_seen : hits_seen + CNT_W'(1);
      end else begin
        misses_seen <= (misses_seen == '1) ? misses_seen : misses_seen + CNT_W'(1);
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      is_hit     <= res.is_hit;
      set_number <= cur_set;
      way_number <= res.way;
    end
  end

  // A transferred access moves on to the lookup state unless a register write comes in the same cycle.
  `SACL_ASSERT_NXT(a_xfer_to_look, clk, rst, in_xfer && !cfg_write_en, state == ST_LOOK, "access did not enter lookup")

  // The reported way lies inside the configured associativity.
  `SACL_ASSERT_IMP(a_way_in_range, clk, rst, done, FILL_W'(res.way) < ways, "way beyond associativity")

  // The fill count written back never exceeds the number of ways.
  `SACL_ASSERT_IMP(a_fill_bound, clk, rst, done, wr_row.fill <= ways, "fill count beyond associativity")

  // Until the access total saturates, hits and misses add up to it.
  `SACL_ASSERT_IMP(a_totals_sum, clk, rst, out_valid && accesses_seen != '1, ((CNT_W+1)'(hits_seen) + (CNT_W+1)'(misses_seen)) == (CNT_W+1)'(accesses_seen), "totals inconsistent")

endmodule
